FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the top-level rtl file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent at the same clock edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must never be true at a clock edge
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: sv/cpmd_pkg.sv
// ---------------------------------------------------------------------------
// cpmd_pkg
// types and constants of the flow/gps position mismatch cusum detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpmd_pkg;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // config port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // saturation limits
   localparam logic [30:0] SUM_MAX = 31'h7FFF_FFFF;
   localparam logic [46:0] TOTAL_MAX = 47'h7FFF_FFFF_FFFF;
   localparam logic [7:0] RUN_MAX = 8'hFF;

   // register reset values
   localparam logic signed [17:0] BASELINE_OFFSET_RST = -18'sd269;
   localparam logic [16:0] SLACK_RST = 17'd856;
   localparam logic [23:0] FIXED_THRESHOLD_RST = 24'd144179;
   localparam logic [16:0] ATTITUDE_SLACK_RST = 17'd1638;
   localparam logic [19:0] ADAPTIVE_SCALE_RST = 20'd98304;
   localparam logic [23:0] ADAPTIVE_FLOOR_RST = 24'd65536;
   localparam logic [7:0] HIT_COUNT_LIMIT_RST = 8'd5;
   localparam logic [30:0] TOTAL_GAP_LIMIT_RST = 31'd655360;

   // register word index
   typedef enum logic [2:0] {
      REG_BASELINE_OFFSET = 3'd0,
      REG_SLACK = 3'd1,
      REG_FIXED_THRESHOLD = 3'd2,
      REG_ATTITUDE_SLACK = 3'd3,
      REG_ADAPTIVE_SCALE = 3'd4,
      REG_ADAPTIVE_FLOOR = 3'd5,
      REG_HIT_COUNT_LIMIT = 3'd6,
      REG_TOTAL_GAP_LIMIT = 3'd7
   } reg_index_type;

   // configuration registers
   typedef struct packed {
      logic signed [17:0] baseline_offset;
      logic [16:0] slack;
      logic [23:0] fixed_threshold;
      logic [16:0] attitude_slack;
      logic [19:0] adaptive_scale;
      logic [23:0] adaptive_floor;
      logic [7:0] hit_count_limit;
      logic [30:0] total_gap_limit;
   } cfg_type;

   // input item
   typedef struct packed {
      logic [19:0] flow_distance;
      logic [19:0] gnss_distance;
      logic flow_moving;
      logic [18:0] attitude_magnitude;
   } req_type;

   // result item
   typedef struct packed {
      logic fixed_hit;
      logic fixed_alarm;
      logic adaptive_hit;
      logic adaptive_alarm;
      logic gap_exceeded;
      logic [30:0] upper_sum;
      logic [30:0] lower_sum;
      logic [30:0] attitude_sum;
      logic [30:0] adaptive_level;
      logic signed [47:0] total_gap;
   } rsp_type;

   // queued work item, with the cusum increments already formed
   typedef struct packed {
      logic signed [22:0] up_step;
      logic signed [22:0] down_step;
      logic [19:0] flow_distance;
      logic [19:0] gnss_distance;
      logic flow_moving;
      logic [18:0] attitude_magnitude;
   } work_type;

   // head of the queue as seen by the back
   typedef struct packed {
      logic valid;
      work_type entry;
   } q_head_type;

endpackage

FILE: sv/cpmd_front.sv
// ---------------------------------------------------------------------------
// cpmd_front
// accepts items, forms the cusum step terms and queues them for the back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpmd_front import cpmd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input cfg_type cfg,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   input logic pop,
   output q_head_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push;
   work_type entry_in;
   logic signed [22:0] diff;
   logic signed [22:0] offset_ext;
   logic signed [22:0] slack_ext;

   // full queue holds off the sender
   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;

   // step terms: flow minus gps against offset and slack
   always_comb begin
      diff = $signed({3'b000, req_data.flow_distance})
           - $signed({3'b000, req_data.gnss_distance});
      offset_ext = {{5{cfg.baseline_offset[17]}}, cfg.baseline_offset};
      slack_ext = $signed({6'b000000, cfg.slack});
      entry_in.up_step = diff - offset_ext - slack_ext;
      entry_in.down_step = offset_ext - diff - slack_ext;
      entry_in.flow_distance = req_data.flow_distance;
      entry_in.gnss_distance = req_data.gnss_distance;
      entry_in.flow_moving = req_data.flow_moving;
      entry_in.attitude_magnitude = req_data.attitude_magnitude;
   end

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

endmodule

FILE: sv/cpmd_back.sv
// ---------------------------------------------------------------------------
// cpmd_back
// three stage datapath: cusum and total update, level product, test and result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpmd_back import cpmd_pkg::*; (
   input logic clock,
   input logic reset,
   input cfg_type cfg,
   input q_head_type head,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   // detector state, updated as an item leaves the queue
   logic [30:0] fixed_upper_ff, fixed_upper_in;
   logic [30:0] fixed_lower_ff, fixed_lower_in;
   logic [30:0] adaptive_upper_ff, adaptive_upper_in;
   logic [30:0] adaptive_lower_ff, adaptive_lower_in;
   logic [30:0] attitude_cusum_ff, attitude_cusum_in;
   logic [18:0] last_attitude_ff, last_attitude_in;
   logic attitude_started_ff, attitude_started_in;
   logic [46:0] flow_total_ff, flow_total_in;
   logic [46:0] gps_total_ff, gps_total_in;
   logic [7:0] fixed_run_ff, fixed_run_in;
   logic [7:0] adaptive_run_ff, adaptive_run_in;

   // stage valid and payload registers
   logic s1_valid_ff, s1_moving_ff;
   logic s2_valid_ff, s2_moving_ff, s2_fixed_hit_ff;
   logic [30:0] s2_fixed_upper_ff, s2_fixed_lower_ff;
   logic [30:0] s2_adaptive_upper_ff, s2_adaptive_lower_ff;
   logic [30:0] s2_attitude_ff;
   logic [50:0] s2_product_ff;
   logic signed [47:0] s2_gap_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic pipe_en;
   logic s2_fixed_hit_in;
   work_type e;
   logic signed [32:0] up_ext, down_ext;
   logic signed [19:0] att_diff;
   logic [18:0] att_abs;
   logic [47:0] flow_sum, gps_sum;
   logic [34:0] level_wide;
   logic [30:0] level;
   logic adaptive_hit;
   logic [7:0] limit;
   logic [47:0] gap_abs;

   // clamp to zero .. SUM_MAX
   function automatic logic [30:0] clamp_sum(input logic signed [32:0] v);
      logic [30:0] r;
      if (v[32]) begin
         r = '0;
      end else if (v[31]) begin
         r = SUM_MAX;
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

   // whole pipeline advances when the result register can move
   assign pipe_en = !rsp_valid_ff || !rsp_stall;
   assign pop = pipe_en && head.valid;
   assign e = head.entry;

   // stage 1: sums, attitude cusum and totals
   always_comb begin
      up_ext = {{10{e.up_step[22]}}, e.up_step};
      down_ext = {{10{e.down_step[22]}}, e.down_step};
      att_diff = $signed({1'b0, e.attitude_magnitude}) - $signed({1'b0, last_attitude_ff});
      att_abs = att_diff[19] ? 19'(-att_diff) : att_diff[18:0];
      flow_sum = {1'b0, flow_total_ff} + {28'd0, e.flow_distance};
      gps_sum = {1'b0, gps_total_ff} + {28'd0, e.gnss_distance};

      fixed_upper_in = fixed_upper_ff;
      fixed_lower_in = fixed_lower_ff;
      adaptive_upper_in = adaptive_upper_ff;
      adaptive_lower_in = adaptive_lower_ff;
      attitude_cusum_in = attitude_cusum_ff;
      last_attitude_in = last_attitude_ff;
      attitude_started_in = attitude_started_ff;
      flow_total_in = flow_total_ff;
      gps_total_in = gps_sum[47] ? TOTAL_MAX : gps_sum[46:0];

      if (e.flow_moving) begin
         flow_total_in = flow_sum[47] ? TOTAL_MAX : flow_sum[46:0];
         fixed_upper_in = clamp_sum($signed({2'b00, fixed_upper_ff}) + up_ext);
         fixed_lower_in = clamp_sum($signed({2'b00, fixed_lower_ff}) + down_ext);
         adaptive_upper_in = clamp_sum($signed({2'b00, adaptive_upper_ff}) + up_ext);
         adaptive_lower_in = clamp_sum($signed({2'b00, adaptive_lower_ff}) + down_ext);
         if (attitude_started_ff) begin
            attitude_cusum_in = clamp_sum($signed({2'b00, attitude_cusum_ff})
                                        + $signed({14'd0, att_abs})
                                        - $signed({16'd0, cfg.attitude_slack}));
         end
         attitude_started_in = 1'b1;
         last_attitude_in = e.attitude_magnitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_upper_ff <= '0;
         fixed_lower_ff <= '0;
         adaptive_upper_ff <= '0;
         adaptive_lower_ff <= '0;
         attitude_cusum_ff <= '0;
         last_attitude_ff <= '0;
         attitude_started_ff <= 1'b0;
         flow_total_ff <= '0;
         gps_total_ff <= '0;
      end else if (pop) begin
         fixed_upper_ff <= fixed_upper_in;
         fixed_lower_ff <= fixed_lower_in;
         adaptive_upper_ff <= adaptive_upper_in;
         adaptive_lower_ff <= adaptive_lower_in;
         attitude_cusum_ff <= attitude_cusum_in;
         last_attitude_ff <= last_attitude_in;
         attitude_started_ff <= attitude_started_in;
         flow_total_ff <= flow_total_in;
         gps_total_ff <= gps_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= head.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_moving_ff <= e.flow_moving;
      end
   end

   // stage 2: level product, fixed test and total gap
   assign s2_fixed_hit_in = s1_moving_ff
                          && ((fixed_upper_ff > {7'd0, cfg.fixed_threshold})
                           || (fixed_lower_ff > {7'd0, cfg.fixed_threshold}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && s1_valid_ff) begin
         s2_moving_ff <= s1_moving_ff;
         s2_fixed_hit_ff <= s2_fixed_hit_in;
         s2_fixed_upper_ff <= fixed_upper_ff;
         s2_fixed_lower_ff <= fixed_lower_ff;
         s2_adaptive_upper_ff <= adaptive_upper_ff;
         s2_adaptive_lower_ff <= adaptive_lower_ff;
         s2_attitude_ff <= attitude_cusum_ff;
         s2_product_ff <= {20'd0, attitude_cusum_ff} * {31'd0, cfg.adaptive_scale};
         s2_gap_ff <= $signed({1'b0, flow_total_ff}) - $signed({1'b0, gps_total_ff});
      end
   end

   // stage 3: adaptive level, adaptive test, hit runs and gap flag
   always_comb begin
      level_wide = s2_product_ff[50:16];
      level = (level_wide[34:31] != 4'd0) ? SUM_MAX : level_wide[30:0];
      if (level < {7'd0, cfg.adaptive_floor}) begin
         level = {7'd0, cfg.adaptive_floor};
      end
      adaptive_hit = s2_moving_ff
                   && ((s2_adaptive_upper_ff > level) || (s2_adaptive_lower_ff > level));
      limit = (cfg.hit_count_limit == 8'd0) ? 8'd1 : cfg.hit_count_limit;

      fixed_run_in = fixed_run_ff;
      adaptive_run_in = adaptive_run_ff;
      if (s2_moving_ff) begin
         if (!s2_fixed_hit_ff) begin
            fixed_run_in = '0;
         end else if (fixed_run_ff != RUN_MAX) begin
            fixed_run_in = fixed_run_ff + 1'b1;
         end
         if (!adaptive_hit) begin
            adaptive_run_in = '0;
         end else if (adaptive_run_ff != RUN_MAX) begin
            adaptive_run_in = adaptive_run_ff + 1'b1;
         end
      end

      gap_abs = s2_gap_ff[47] ? 48'(-s2_gap_ff) : 48'(s2_gap_ff);

      rsp_data_in.fixed_hit = s2_fixed_hit_ff;
      rsp_data_in.fixed_alarm = (fixed_run_in >= limit);
      rsp_data_in.adaptive_hit = adaptive_hit;
      rsp_data_in.adaptive_alarm = (adaptive_run_in >= limit);
      rsp_data_in.gap_exceeded = (gap_abs > {17'd0, cfg.total_gap_limit});
      rsp_data_in.upper_sum = s2_fixed_upper_ff;
      rsp_data_in.lower_sum = s2_fixed_lower_ff;
      rsp_data_in.attitude_sum = s2_attitude_ff;
      rsp_data_in.adaptive_level = level;
      rsp_data_in.total_gap = s2_gap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_run_ff <= '0;
         adaptive_run_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            fixed_run_ff <= fixed_run_in;
            adaptive_run_ff <= adaptive_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

FILE: sv/cusum_position_mismatch_detector_unit.sv
// ---------------------------------------------------------------------------
// cusum_position_mismatch_detector_unit
// flow/gps distance mismatch detector with fixed and attitude-adaptive cusum
//
//   channel   ports                          direction  moves
//   req       req_valid req_stall req_data   in         one paired update
//   rsp       rsp_valid rsp_stall rsp_data   out        one detector result
//   csr       csr_psel .. csr_prdata         in/out     register read/write
//
// one item per cycle while rsp_stall stays low; a transfer in passes through the
// queue entry, the update stage, the level multiply stage and then the result
// register before it appears as a result.
// the 31x20 level multiply has a stage of its own ahead of the adaptive test.
// reset is synchronous: registers take their defaults, all sums clear.
// rsp_stall freezes the back pipeline; the queue keeps taking items until
// it fills, then req_stall rises.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cusum_position_mismatch_detector_unit import cpmd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg_ff, cfg_in;
   reg_index_type reg_index;
   logic csr_write;
   q_head_type head;
   logic pop;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_BASELINE_OFFSET: cfg_in.baseline_offset = $signed(csr_pwdata[17:0]);
            REG_SLACK: cfg_in.slack = csr_pwdata[16:0];
            REG_FIXED_THRESHOLD: cfg_in.fixed_threshold = csr_pwdata[23:0];
            REG_ATTITUDE_SLACK: cfg_in.attitude_slack = csr_pwdata[16:0];
            REG_ADAPTIVE_SCALE: cfg_in.adaptive_scale = csr_pwdata[19:0];
            REG_ADAPTIVE_FLOOR: cfg_in.adaptive_floor = csr_pwdata[23:0];
            REG_HIT_COUNT_LIMIT: cfg_in.hit_count_limit = csr_pwdata[7:0];
            REG_TOTAL_GAP_LIMIT: cfg_in.total_gap_limit = csr_pwdata[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline_offset <= BASELINE_OFFSET_RST;
         cfg_ff.slack <= SLACK_RST;
         cfg_ff.fixed_threshold <= FIXED_THRESHOLD_RST;
         cfg_ff.attitude_slack <= ATTITUDE_SLACK_RST;
         cfg_ff.adaptive_scale <= ADAPTIVE_SCALE_RST;
         cfg_ff.adaptive_floor <= ADAPTIVE_FLOOR_RST;
         cfg_ff.hit_count_limit <= HIT_COUNT_LIMIT_RST;
         cfg_ff.total_gap_limit <= TOTAL_GAP_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      unique case (reg_index)
         REG_BASELINE_OFFSET:
            csr_prdata = {{14{cfg_ff.baseline_offset[17]}}, cfg_ff.baseline_offset};
         REG_SLACK: csr_prdata = {15'd0, cfg_ff.slack};
         REG_FIXED_THRESHOLD: csr_prdata = {8'd0, cfg_ff.fixed_threshold};
         REG_ATTITUDE_SLACK: csr_prdata = {15'd0, cfg_ff.attitude_slack};
         REG_ADAPTIVE_SCALE: csr_prdata = {12'd0, cfg_ff.adaptive_scale};
         REG_ADAPTIVE_FLOOR: csr_prdata = {8'd0, cfg_ff.adaptive_floor};
         REG_HIT_COUNT_LIMIT: csr_prdata = {24'd0, cfg_ff.hit_count_limit};
         REG_TOTAL_GAP_LIMIT: csr_prdata = {1'b0, cfg_ff.total_gap_limit};
      endcase
   end

   // front: accept and queue
   cpmd_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .pop(pop),
      .head(head)
   );

   // back: detector datapath and result register
   cpmd_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // checks
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && !head.valid, "pop from empty queue")
   `ASSERT_IMPLY(a_level_floor, clock, reset, rsp_valid,
      (rsp_data.adaptive_level >= {7'd0, cfg_ff.adaptive_floor}), "adaptive level below floor")
   `ASSERT_IMPLY(a_fixed_hit, clock, reset, rsp_valid && rsp_data.fixed_hit,
      (rsp_data.upper_sum > {7'd0, cfg_ff.fixed_threshold})
      || (rsp_data.lower_sum > {7'd0, cfg_ff.fixed_threshold}),
      "fixed hit without a sum above threshold")

endmodule

FILE: test/tb_cusum_position_mismatch_detector_unit.sv
// ---------------------------------------------------------------------------
// tb_cusum_position_mismatch_detector_unit
// self-checking bench for the flow/gps mismatch cusum detector: a scoreboard
// class tracks the fixed, adaptive and attitude sums, the hit runs and the
// distance totals for every accepted update, and compares each result
// transfer field by field. stimulus runs a directed opening, then random
// phases under minimum, maximum, random and saturating register settings,
// with random idling on both channels and two long result hold-offs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cusum_position_mismatch_detector_unit;
   import cpmd_pkg::*;

   localparam logic [19:0] DIST_MAX = 20'hFFFFF;
   localparam logic [18:0] ATT_MAX = 19'd393215;

   // expected results of the detector, one per accepted update
   class cusum_tracker;
      cfg_type regs;
      logic [30:0] fix_up, fix_dn, ada_up, ada_dn, att_sum;
      logic [18:0] prev_att;
      bit att_seen;
      logic [7:0] fix_run, ada_run;
      logic [46:0] flow_acc, gps_acc;
      rsp_type pending_reports[$];
      int unsigned fail_count;
      int unsigned report_count;

      function new();
         regs.baseline_offset = BASELINE_OFFSET_RST;
         regs.slack = SLACK_RST;
         regs.fixed_threshold = FIXED_THRESHOLD_RST;
         regs.attitude_slack = ATTITUDE_SLACK_RST;
         regs.adaptive_scale = ADAPTIVE_SCALE_RST;
         regs.adaptive_floor = ADAPTIVE_FLOOR_RST;
         regs.hit_count_limit = HIT_COUNT_LIMIT_RST;
         regs.total_gap_limit = TOTAL_GAP_LIMIT_RST;
         fix_up = '0;
         fix_dn = '0;
         ada_up = '0;
         ada_dn = '0;
         att_sum = '0;
         prev_att = '0;
         att_seen = 1'b0;
         fix_run = '0;
         ada_run = '0;
         flow_acc = '0;
         gps_acc = '0;
         fail_count = 0;
         report_count = 0;
      endfunction

      // floor at zero, saturate at the 31 bit maximum
      function logic [30:0] clamp_sum(longint v);
         if (v < 0) return '0;
         if (v > longint'(SUM_MAX)) return SUM_MAX;
         return v[30:0];
      endfunction

      function logic [46:0] add_total(logic [46:0] t, logic [19:0] d);
         logic [47:0] s;
         s = {1'b0, t} + 48'(d);
         return (s > 48'(TOTAL_MAX)) ? TOTAL_MAX : s[46:0];
      endfunction

      function logic [7:0] next_run(logic [7:0] run, bit hit);
         if (!hit) return '0;
         return (run == RUN_MAX) ? RUN_MAX : run + 8'd1;
      endfunction

      // scaled attitude sum, saturated, never below the floor
      function logic [30:0] adaptive_level_now();
         logic [63:0] p;
         p = (64'(att_sum) * 64'(regs.adaptive_scale)) >> 16;
         if (p > 64'(SUM_MAX)) p = 64'(SUM_MAX);
         if (p < 64'(regs.adaptive_floor)) p = 64'(regs.adaptive_floor);
         return p[30:0];
      endfunction

      // advance the detector state by one update and queue its result
      function void note_update(req_type r);
         longint diff, up, dn, ofs, d, g, ag;
         logic [30:0] lv;
         logic [7:0] lim;
         bit fh, ah;
         rsp_type e;
         lim = (regs.hit_count_limit == 8'd0) ? 8'd1 : regs.hit_count_limit;
         fh = 1'b0;
         ah = 1'b0;
         gps_acc = add_total(gps_acc, r.gnss_distance);
         if (r.flow_moving) begin
            ofs = longint'($signed(regs.baseline_offset));
            diff = longint'(r.flow_distance) - longint'(r.gnss_distance);
            up = diff - ofs - longint'(regs.slack);
            dn = -diff + ofs - longint'(regs.slack);
            flow_acc = add_total(flow_acc, r.flow_distance);
            fix_up = clamp_sum(longint'(fix_up) + up);
            fix_dn = clamp_sum(longint'(fix_dn) + dn);
            fh = (fix_up > regs.fixed_threshold) || (fix_dn > regs.fixed_threshold);
            fix_run = next_run(fix_run, fh);
            // attitude cusum skips the very first moving step
            if (att_seen) begin
               d = longint'(r.attitude_magnitude) - longint'(prev_att);
               if (d < 0) d = -d;
               att_sum = clamp_sum(longint'(att_sum) + d - longint'(regs.attitude_slack));
            end
            att_seen = 1'b1;
            prev_att = r.attitude_magnitude;
            lv = adaptive_level_now();
            ada_up = clamp_sum(longint'(ada_up) + up);
            ada_dn = clamp_sum(longint'(ada_dn) + dn);
            ah = (ada_up > lv) || (ada_dn > lv);
            ada_run = next_run(ada_run, ah);
         end
         g = longint'(flow_acc) - longint'(gps_acc);
         ag = (g < 0) ? -g : g;
         e.fixed_hit = fh;
         e.fixed_alarm = (fix_run >= lim);
         e.adaptive_hit = ah;
         e.adaptive_alarm = (ada_run >= lim);
         e.gap_exceeded = (ag > longint'(regs.total_gap_limit));
         e.upper_sum = fix_up;
         e.lower_sum = fix_dn;
         e.attitude_sum = att_sum;
         e.adaptive_level = adaptive_level_now();
         e.total_gap = g[47:0];
         pending_reports.push_back(e);
      endfunction

      function void match(string field, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, seen);
            fail_count++;
         end
      endfunction

      // compare one result transfer with the oldest pending result
      function void check_report(rsp_type got);
         rsp_type e;
         if (pending_reports.size() == 0) begin
            $error("result transfer with no pending update");
            fail_count++;
            return;
         end
         e = pending_reports.pop_front();
         report_count++;
         match("fixed_hit", 64'(e.fixed_hit), 64'(got.fixed_hit));
         match("fixed_alarm", 64'(e.fixed_alarm), 64'(got.fixed_alarm));
         match("adaptive_hit", 64'(e.adaptive_hit), 64'(got.adaptive_hit));
         match("adaptive_alarm", 64'(e.adaptive_alarm), 64'(got.adaptive_alarm));
         match("gap_exceeded", 64'(e.gap_exceeded), 64'(got.gap_exceeded));
         match("upper_sum", 64'(e.upper_sum), 64'(got.upper_sum));
         match("lower_sum", 64'(e.lower_sum), 64'(got.lower_sum));
         match("attitude_sum", 64'(e.attitude_sum), 64'(got.attitude_sum));
         match("adaptive_level", 64'(e.adaptive_level), 64'(got.adaptive_level));
         match("total_gap", 64'(e.total_gap), 64'(got.total_gap));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   cusum_tracker tracker;
   int unsigned sent_count = 0;
   int unsigned directed_count = 0;
   bit send_quiet = 1'b0;
   int att_walk = 0;

   cusum_position_mismatch_detector_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   function automatic req_type make_update(logic [19:0] flow, logic [19:0] gps, logic moving,
                                           logic [18:0] att);
      req_type r;
      r.flow_distance = flow;
      r.gnss_distance = gps;
      r.flow_moving = moving;
      r.attitude_magnitude = att;
      return r;
   endfunction

   // random update: mostly paired distances close together, some extremes
   function automatic req_type random_update(bit drift);
      req_type r;
      int unsigned sel, base;
      int f;
      if (drift) begin
         // steady large flow excess to push sums, runs and level to saturation
         r.flow_moving = ($urandom_range(0, 29) != 0);
         r.flow_distance = 20'($urandom_range(1040000, 1048575));
         r.gnss_distance = 20'($urandom_range(0, 600));
         r.attitude_magnitude = $urandom_range(0, 1) ? ATT_MAX : 19'd0;
         return r;
      end
      sel = $urandom_range(0, 9);
      r.flow_moving = ($urandom_range(0, 4) != 0);
      if (sel == 0) begin
         r.flow_distance = $urandom_range(0, 1) ? DIST_MAX : 20'd0;
         r.gnss_distance = $urandom_range(0, 1) ? DIST_MAX : 20'd0;
      end else if (sel < 7) begin
         base = $urandom_range(0, 1048575);
         f = int'(base) + int'($urandom_range(0, 6000)) - 3000;
         if (f < 0) f = 0;
         if (f > 1048575) f = 1048575;
         r.gnss_distance = 20'(base);
         r.flow_distance = 20'(f);
      end else begin
         r.flow_distance = 20'($urandom_range(0, 1048575));
         r.gnss_distance = 20'($urandom_range(0, 1048575));
      end
      // attitude mostly wanders slowly, sometimes jumps
      if ($urandom_range(0, 3) == 0) begin
         att_walk = $urandom_range(0, 393215);
      end else begin
         att_walk = att_walk + int'($urandom_range(0, 4000)) - 2000;
         if (att_walk < 0) att_walk = 0;
         if (att_walk > 393215) att_walk = 393215;
      end
      r.attitude_magnitude = 19'(att_walk);
      return r;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int v;
      v = int'($urandom_range(0, 131072)) - 65536;
      c.baseline_offset = 18'(v);
      c.slack = 17'($urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 65536));
      c.fixed_threshold = 24'($urandom_range(0, 3000000));
      c.attitude_slack = 17'($urandom_range(0, 8000));
      c.adaptive_scale = 20'($urandom_range(0, 1048575));
      c.adaptive_floor = 24'($urandom_range(0, 2000000));
      c.hit_count_limit = 8'($urandom_range(1, 12));
      c.total_gap_limit = 31'($urandom_range(0, 40000000));
      return c;
   endfunction

   // one update transfer, after a random idle gap
   task automatic send_update(req_type item);
      int unsigned gap;
      gap = send_quiet ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 24) == 0) send_quiet = !send_quiet;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.note_update(item);
      sent_count++;
   endtask

   // register write: setup phase, then access phase until pready
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic load_registers(cfg_type c);
      csr_write(REG_BASELINE_OFFSET, 32'(c.baseline_offset));
      csr_write(REG_SLACK, 32'(c.slack));
      csr_write(REG_FIXED_THRESHOLD, 32'(c.fixed_threshold));
      csr_write(REG_ATTITUDE_SLACK, 32'(c.attitude_slack));
      csr_write(REG_ADAPTIVE_SCALE, 32'(c.adaptive_scale));
      csr_write(REG_ADAPTIVE_FLOOR, 32'(c.adaptive_floor));
      csr_write(REG_HIT_COUNT_LIMIT, 32'(c.hit_count_limit));
      csr_write(REG_TOTAL_GAP_LIMIT, 32'(c.total_gap_limit));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      tracker.regs = c;
   endtask

   // wait until every result is back, then past the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // result side: random stalls, two long hold-offs so the queue fills
   initial begin : result_sink
      int unsigned hold;
      int unsigned taken;
      bit quiet;
      quiet = 1'b0;
      taken = 0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 14);
         if ($urandom_range(0, 24) == 0) quiet = !quiet;
         if (taken == 300 || taken == 1300) hold = 90;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
         tracker.check_report(rsp_data);
         taken++;
      end
   end

   initial begin : stimulus
      cfg_type c;
      int unsigned n;
      bit drift;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening at reset settings
      send_update(make_update(DIST_MAX, DIST_MAX, 1'b0, ATT_MAX));
      send_update(make_update(20'd0, 20'd0, 1'b1, ATT_MAX));
      send_update(make_update(DIST_MAX, 20'd0, 1'b1, 19'd0));
      send_update(make_update(20'd0, DIST_MAX, 1'b1, ATT_MAX));
      send_update(make_update(DIST_MAX, DIST_MAX, 1'b1, 19'd0));
      send_update(make_update(20'd12345, 20'd0, 1'b0, 19'd0));
      // consecutive hits build the run up to an alarm
      for (int i = 0; i < 7; i++) begin
         send_update(make_update(20'd300000, 20'd100000, 1'b1, 19'(1000 * i)));
      end
      send_update(make_update(20'd500, 20'd700, 1'b0, 19'd0));
      // reversal drops the upper sum, a miss clears the run
      send_update(make_update(20'd0, DIST_MAX, 1'b1, 19'd0));
      send_update(make_update(20'd0, DIST_MAX, 1'b1, 19'd0));
      send_update(make_update(20'd0, 20'd0, 1'b1, 19'd0));
      send_update(make_update(DIST_MAX, 20'd0, 1'b1, ATT_MAX));
      send_update(make_update(DIST_MAX, 20'd0, 1'b0, ATT_MAX));
      directed_count = sent_count;
      settle();

      // random phases under changing register settings
      for (int p = 0; p < 7; p++) begin
         c = random_settings();
         drift = 1'b0;
         n = 105;
         case (p)
            0: begin
               c.baseline_offset = -18'sd65536;
               c.slack = '0;
               c.fixed_threshold = '0;
               c.attitude_slack = '0;
               c.adaptive_scale = '0;
               c.adaptive_floor = '0;
               c.hit_count_limit = 8'd1;
               c.total_gap_limit = '0;
            end
            1: begin
               c.baseline_offset = 18'sd65536;
               c.slack = 17'd65536;
               c.fixed_threshold = 24'd16777215;
               c.attitude_slack = 17'd65536;
               c.adaptive_scale = 20'd1048575;
               c.adaptive_floor = 24'd16777215;
               c.hit_count_limit = 8'd255;
               c.total_gap_limit = 31'h7FFF_FFFF;
            end
            // zero hit limit acts as a limit of one
            2: c.hit_count_limit = 8'd0;
            3: begin
               c.baseline_offset = -18'sd65536;
               c.slack = '0;
               c.fixed_threshold = FIXED_THRESHOLD_RST;
               c.attitude_slack = '0;
               c.adaptive_scale = 20'd1048575;
               c.adaptive_floor = ADAPTIVE_FLOOR_RST;
               c.hit_count_limit = 8'd255;
               c.total_gap_limit = 31'h7FFF_FFFF;
               drift = 1'b1;
               n = 1100;
            end
            default: ;
         endcase
         load_registers(c);
         for (int i = 0; i < n; i++) begin
            send_update(random_update(drift));
         end
         settle();
      end

      if (tracker.pending_reports.size() != 0) begin
         $error("%0d results never arrived", tracker.pending_reports.size());
         tracker.fail_count++;
      end
      $display("checked %0d results from %0d updates (%0d directed) over 8 register settings",
               tracker.report_count, sent_count, directed_count);
      $display("settings spanned all-minimum, all-maximum, zero hit limit and a long drift");
      if (tracker.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // generous bound on the slowest correct run
   initial begin : watchdog
      #(64'd600000 * 12);
      $display("timeout: results stopped arriving");
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: cusum_position_mismatch_detector_unit.f
+incdir+sv
sv/cpmd_pkg.sv
sv/cpmd_front.sv
sv/cpmd_back.sv
sv/cusum_position_mismatch_detector_unit.sv
test/tb_cusum_position_mismatch_detector_unit.sv
